// File: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int CAPACITY  = 1024;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = 11;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int HASH_W    = 32;
    localparam int HBIT_W    = $clog2(HASH_W);

    localparam logic [CNT_W-1:0] SLOT_RESET = CNT_W'(59);
    localparam logic [CNT_W-1:0] SLOT_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] SLOT_MAX   = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_ERASE  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FOUND    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2,
        MARK_SPARE = 2'd3
    } mark_t;

    typedef struct packed {
        mark_t             mark;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_if
// Request and response channels of the linear probing hash table.
// ----------------------------------------------------------------------------
interface lpht_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [lpht_pkg::KEY_W-1:0]  key;
    logic [lpht_pkg::HASH_W-1:0] key_hash;
    logic [lpht_pkg::VAL_W-1:0]  value;

    modport source (output valid, action, key, key_hash, value, input ready);
    modport sink (input valid, action, key, key_hash, value, output ready);
endinterface

interface lpht_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [lpht_pkg::VAL_W-1:0] found_value;
    logic [lpht_pkg::CNT_W-1:0] used_slots;

    modport source (output valid, status, found_value, used_slots, input ready);
    modport sink (input valid, status, found_value, used_slots, output ready);
endinterface

// File: rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and tombstones.
// ----------------------------------------------------------------------------
//  Channel  Role    Word
//  req      sink    action, key, key_hash, value
//  rsp      source  status, found_value, used_slots
//  cfg      write   slot_count
//
// After reset the table sweeps all slots empty, taking no request meanwhile.
// A request reduces its hash to a home slot bit by bit, checks slots in turn, then
// loads the response. A drop reads the next slot, then marks the slot empty or a
// tombstone; a move-back moves the entry to the first tombstone and drops the old
// slot; an erase then drops the moved entry. The single slot RAM and its registered
// read set the probe rate. A waiting response does not block the next request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0] cfg_wdata,
    lpht_req_if.sink                   req,
    lpht_rsp_if.source                 rsp
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MOD   = 9'b000000100,
        S_RD    = 9'b000001000,
        S_EV    = 9'b000010000,
        S_MV    = 9'b000100000,
        S_DRD   = 9'b001000000,
        S_DEV   = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [lpht_pkg::CNT_W-1:0]      slots_reg;
    logic [lpht_pkg::CNT_W-1:0]      used_reg, used_next;
    logic [lpht_pkg::IDX_W-1:0]      clr_reg, clr_next;
    lpht_pkg::action_t               act_reg, act_next;
    logic [lpht_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [lpht_pkg::HASH_W-1:0]     hash_reg, hash_next;
    logic [lpht_pkg::VAL_W-1:0]      val_reg, val_next;
    logic [lpht_pkg::IDX_W-1:0]      rem_reg, rem_next;
    logic [lpht_pkg::HBIT_W-1:0]     bit_reg, bit_next;
    logic [lpht_pkg::IDX_W-1:0]      p_reg, p_next;
    logic [lpht_pkg::IDX_W-1:0]      home_reg, home_next;
    logic [lpht_pkg::CNT_W-1:0]      i_reg, i_next;
    logic [lpht_pkg::IDX_W-1:0]      tomb_reg, tomb_next;
    logic                            have_tomb_reg, have_tomb_next;
    lpht_pkg::entry_t                ent_reg, ent_next;
    logic [lpht_pkg::IDX_W-1:0]      q_reg, q_next;
    logic                            drop2_reg, drop2_next;
    lpht_pkg::status_t               status_reg, status_next;
    logic [lpht_pkg::VAL_W-1:0]      fval_reg, fval_next;
    logic                            ov_reg, ov_next;
    logic [1:0]                      ostat_reg, ostat_next;
    logic [lpht_pkg::VAL_W-1:0]      ofval_reg, ofval_next;
    logic [lpht_pkg::CNT_W-1:0]      oused_reg, oused_next;

    logic [lpht_pkg::CNT_W-1:0]      n_eff;
    logic [lpht_pkg::CNT_W-1:0]      mod_t;
    logic [lpht_pkg::IDX_W-1:0]      mod_r;
    logic [lpht_pkg::IDX_W-1:0]      p_nxt;
    logic [lpht_pkg::IDX_W-1:0]      q_nxt;
    logic [lpht_pkg::CNT_W-1:0]      i_inc;
    logic                            ram_we;
    logic [lpht_pkg::IDX_W-1:0]      ram_waddr;
    lpht_pkg::entry_t                ram_wdata;
    logic [lpht_pkg::IDX_W-1:0]      ram_raddr;
    lpht_pkg::entry_t                ram_rdata;

    lpht_ram #(
        .WIDTH (lpht_pkg::ENTRY_W),
        .DEPTH (lpht_pkg::CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (slots_reg < lpht_pkg::SLOT_MIN)
        begin
            n_eff = lpht_pkg::SLOT_MIN;
        end
        else if (slots_reg > lpht_pkg::SLOT_MAX)
        begin
            n_eff = lpht_pkg::SLOT_MAX;
        end
        else
        begin
            n_eff = slots_reg;
        end
    end

    assign mod_t = {rem_reg, hash_reg[lpht_pkg::HASH_W-1]};
    assign mod_r = (mod_t >= n_eff) ? lpht_pkg::IDX_W'(mod_t - n_eff)
                                    : lpht_pkg::IDX_W'(mod_t);
    assign p_nxt = ((lpht_pkg::CNT_W'(p_reg) + 1'b1) == n_eff) ? '0 : p_reg + 1'b1;
    assign q_nxt = ((lpht_pkg::CNT_W'(q_reg) + 1'b1) == n_eff) ? '0 : q_reg + 1'b1;
    assign i_inc = i_reg + 1'b1;
    assign ram_raddr = (state_reg == S_DRD) ? q_nxt : p_reg;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = ov_reg;
    assign rsp.status      = ostat_reg;
    assign rsp.found_value = ofval_reg;
    assign rsp.used_slots  = oused_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        clr_next       = clr_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        val_next       = val_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        p_next         = p_reg;
        home_next      = home_reg;
        i_next         = i_reg;
        tomb_next      = tomb_reg;
        have_tomb_next = have_tomb_reg;
        ent_next       = ent_reg;
        q_next         = q_reg;
        drop2_next     = drop2_reg;
        status_next    = status_reg;
        fval_next      = fval_reg;
        ov_next        = ov_reg & ~rsp.ready;
        ostat_next     = ostat_reg;
        ofval_next     = ofval_reg;
        oused_next     = oused_reg;
        ram_we         = 1'b0;
        ram_waddr      = p_reg;
        ram_wdata      = ent_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == lpht_pkg::IDX_W'(lpht_pkg::CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next       = lpht_pkg::action_t'(req.action);
                    key_next       = req.key;
                    hash_next      = req.key_hash;
                    val_next       = req.value;
                    rem_next       = '0;
                    bit_next       = '0;
                    i_next         = '0;
                    have_tomb_next = 1'b0;
                    drop2_next     = 1'b0;
                    fval_next      = '0;
                    if (lpht_pkg::action_t'(req.action) == lpht_pkg::ACT_NONE)
                    begin
                        status_next = lpht_pkg::ST_NOTFOUND;
                        state_next  = S_RESP;
                    end
                    else if (lpht_pkg::action_t'(req.action) == lpht_pkg::ACT_INSERT
                             && used_reg >= n_eff - 1'b1)
                    begin
                        status_next = lpht_pkg::ST_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                rem_next  = mod_r;
                hash_next = hash_reg << 1;
                bit_next  = bit_reg + 1'b1;
                if (bit_reg == lpht_pkg::HBIT_W'(lpht_pkg::HASH_W - 1))
                begin
                    p_next     = mod_r;
                    home_next  = mod_r;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                state_next = S_RD;
                if (act_reg == lpht_pkg::ACT_INSERT && ram_rdata.mark != lpht_pkg::MARK_USED)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = p_reg;
                    ram_wdata.mark  = lpht_pkg::MARK_USED;
                    ram_wdata.key   = key_reg;
                    ram_wdata.value = val_reg;
                    if (ram_rdata.mark == lpht_pkg::MARK_EMPTY)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                    status_next = lpht_pkg::ST_OK;
                    state_next  = S_RESP;
                end
                else if (act_reg != lpht_pkg::ACT_INSERT
                         && ram_rdata.mark == lpht_pkg::MARK_EMPTY)
                begin
                    status_next = lpht_pkg::ST_NOTFOUND;
                    state_next  = S_RESP;
                end
                else if (act_reg != lpht_pkg::ACT_INSERT
                         && ram_rdata.mark == lpht_pkg::MARK_USED
                         && ram_rdata.key == key_reg)
                begin
                    ent_next = ram_rdata;
                    if (p_reg != home_reg && have_tomb_reg)
                    begin
                        state_next = S_MV;
                    end
                    else if (act_reg == lpht_pkg::ACT_FIND)
                    begin
                        status_next = lpht_pkg::ST_FOUND;
                        fval_next   = ram_rdata.value;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        q_next     = p_reg;
                        state_next = S_DRD;
                    end
                end
                else
                begin
                    if (act_reg != lpht_pkg::ACT_INSERT
                        && ram_rdata.mark == lpht_pkg::MARK_TOMB && !have_tomb_reg)
                    begin
                        tomb_next      = p_reg;
                        have_tomb_next = 1'b1;
                    end
                    p_next = p_nxt;
                    i_next = i_inc;
                    if (i_inc == n_eff)
                    begin
                        status_next = (act_reg == lpht_pkg::ACT_INSERT) ? lpht_pkg::ST_FULL
                                                                        : lpht_pkg::ST_NOTFOUND;
                        state_next  = S_RESP;
                    end
                end
            end
            S_MV:
            begin
                ram_we         = 1'b1;
                ram_waddr      = tomb_reg;
                ram_wdata      = ent_reg;
                ram_wdata.mark = lpht_pkg::MARK_USED;
                q_next         = p_reg;
                p_next         = tomb_reg;
                drop2_next     = (act_reg == lpht_pkg::ACT_ERASE);
                state_next     = S_DRD;
            end
            S_DRD:
            begin
                state_next = S_DEV;
            end
            S_DEV:
            begin
                ram_we    = 1'b1;
                ram_waddr = q_reg;
                ram_wdata = ent_reg;
                if (ram_rdata.mark == lpht_pkg::MARK_EMPTY)
                begin
                    ram_wdata.mark = lpht_pkg::MARK_EMPTY;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - 1'b1;
                    end
                end
                else
                begin
                    ram_wdata.mark = lpht_pkg::MARK_TOMB;
                end
                if (drop2_reg)
                begin
                    q_next     = p_reg;
                    drop2_next = 1'b0;
                    state_next = S_DRD;
                end
                else if (act_reg == lpht_pkg::ACT_FIND)
                begin
                    status_next = lpht_pkg::ST_FOUND;
                    fval_next   = ent_reg.value;
                    state_next  = S_RESP;
                end
                else
                begin
                    status_next = lpht_pkg::ST_OK;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    ostat_next = status_reg;
                    ofval_next = fval_reg;
                    oused_next = used_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            slots_reg <= lpht_pkg::SLOT_RESET;
            used_reg  <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                slots_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        hash_reg      <= hash_next;
        val_reg       <= val_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        p_reg         <= p_next;
        home_reg      <= home_next;
        i_reg         <= i_next;
        tomb_reg      <= tomb_next;
        have_tomb_reg <= have_tomb_next;
        ent_reg       <= ent_next;
        q_reg         <= q_next;
        drop2_reg     <= drop2_next;
        status_reg    <= status_next;
        fval_reg      <= fval_next;
        ostat_reg     <= ostat_next;
        ofval_reg     <= ofval_next;
        oused_reg     <= oused_next;
    end

endmodule

// File: rtl/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_assert
// Port-level checks of the linear probing hash table.
// ----------------------------------------------------------------------------
module lpht_assert (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [1:0]                 rsp_status,
    input logic [lpht_pkg::VAL_W-1:0] rsp_found_value,
    input logic [lpht_pkg::CNT_W-1:0] rsp_used_slots
);

    logic [1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
        end
    end

    // Every response word answers a request that was taken earlier.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != '0)
        else $error("response without a pending request");

    a_fval_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != lpht_pkg::ST_FOUND |-> rsp_found_value == '0)
        else $error("found_value set on a miss");

    a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_used_slots <= lpht_pkg::SLOT_MAX)
        else $error("used_slots beyond capacity");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_used_slots))
        else $error("stalled response word changed");

endmodule

bind linear_probe_hash_table lpht_assert u_lpht_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found_value (rsp.found_value),
    .rsp_used_slots  (rsp.used_slots)
);

// File: tb/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the request, response and register channels of the hash table,
// keeps its own copy of the slots and the count, works out the response to
// every accepted request word and compares each response word with it.
// ----------------------------------------------------------------------------
module lpht_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0] cfg_wdata,
    lpht_req_if                        req,
    lpht_rsp_if                        rsp,
    output int                         fail_count,
    output int                         pending
);
    import lpht_pkg::*;

    typedef struct {
        status_t          status;
        logic [VAL_W-1:0] found_value;
        logic [CNT_W-1:0] used_slots;
    } outcome_t;

    outcome_t         outcome_q[$];
    mark_t            slot_marks[CAPACITY];
    logic [KEY_W-1:0] slot_keys[CAPACITY];
    logic [VAL_W-1:0] slot_vals[CAPACITY];
    int unsigned      used_cnt;
    logic [CNT_W-1:0] slot_reg;
    int               fails;

    function automatic int unsigned live_slots();
        if (slot_reg < SLOT_MIN)
            return SLOT_MIN;
        if (slot_reg > SLOT_MAX)
            return SLOT_MAX;
        return slot_reg;
    endfunction

    function automatic void vacate(int unsigned p, int unsigned n);
        if (slot_marks[(p + 1) % n] == MARK_EMPTY)
        begin
            slot_marks[p] = MARK_EMPTY;
            if (used_cnt > 0)
                used_cnt--;
        end
        else
            slot_marks[p] = MARK_TOMB;
    endfunction

    function automatic bit probe_key(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                                     int unsigned n, output int unsigned where);
        int unsigned home;
        int unsigned p;
        int unsigned tomb;
        bit          have_tomb;
        home      = h % n;
        p         = home;
        tomb      = 0;
        have_tomb = 0;
        where     = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (slot_marks[p] == MARK_EMPTY)
                return 0;
            if (slot_marks[p] == MARK_TOMB)
            begin
                if (!have_tomb)
                begin
                    tomb      = p;
                    have_tomb = 1;
                end
            end
            else if (slot_keys[p] == k)
            begin
                if (p != home && have_tomb)
                begin
                    slot_keys[tomb]  = slot_keys[p];
                    slot_vals[tomb]  = slot_vals[p];
                    slot_marks[tomb] = MARK_USED;
                    vacate(p, n);
                    p = tomb;
                end
                where = p;
                return 1;
            end
            p = (p + 1) % n;
        end
        return 0;
    endfunction

    function automatic outcome_t table_response(action_t act, logic [KEY_W-1:0] k,
                                                logic [HASH_W-1:0] h,
                                                logic [VAL_W-1:0] v);
        outcome_t    o;
        int unsigned n;
        int unsigned p;
        n             = live_slots();
        o.status      = ST_NOTFOUND;
        o.found_value = '0;
        case (act)
            ACT_INSERT:
            begin
                o.status = ST_FULL;
                if (used_cnt < n - 1)
                begin
                    p = h % n;
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        if (slot_marks[p] != MARK_USED)
                        begin
                            if (slot_marks[p] == MARK_EMPTY)
                                used_cnt++;
                            slot_marks[p] = MARK_USED;
                            slot_keys[p]  = k;
                            slot_vals[p]  = v;
                            o.status      = ST_OK;
                            break;
                        end
                        p = (p + 1) % n;
                    end
                end
            end
            ACT_FIND:
            begin
                if (probe_key(k, h, n, p))
                begin
                    o.status      = ST_FOUND;
                    o.found_value = slot_vals[p];
                end
            end
            ACT_ERASE:
            begin
                if (probe_key(k, h, n, p))
                begin
                    vacate(p, n);
                    o.status = ST_OK;
                end
            end
            default: ;
        endcase
        o.used_slots = CNT_W'(used_cnt);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            foreach (slot_marks[i])
                slot_marks[i] = MARK_EMPTY;
            used_cnt = 0;
            slot_reg = SLOT_RESET;
            fails    = 0;
            outcome_q.delete();
        end
        else
        begin
            if (cfg_we)
                slot_reg = cfg_wdata;
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("response word with no request outstanding");
                    fails++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        fails++;
                    end
                    if (rsp.found_value !== want.found_value)
                    begin
                        $error("found_value: expected %0h, actual %0h",
                               want.found_value, rsp.found_value);
                        fails++;
                    end
                    if (rsp.used_slots !== want.used_slots)
                    begin
                        $error("used_slots: expected %0d, actual %0d",
                               want.used_slots, rsp.used_slots);
                        fails++;
                    end
                end
            end
            if (req.valid && req.ready)
                outcome_q.push_back(table_response(action_t'(req.action), req.key,
                                                   req.key_hash, req.value));
        end
        fail_count <= fails;
        pending    <= outcome_q.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the hash table with a directed run through collisions, tombstones,
// move-back on find and a full table, then with random requests on a small
// pool of keys under a series of slot counts, with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import lpht_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    bit               quiet;
    int               stall_left;

    logic [KEY_W-1:0]  pool_keys[12];
    logic [HASH_W-1:0] pool_hashes[12];

    lpht_req_if req ();
    lpht_rsp_if rsp ();

    linear_probe_hash_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    lpht_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("** linear_probe_hash_table: FAILED **");
        $finish;
    end

    initial
    begin
        rsp.ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 20)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    task automatic send_request(action_t a, logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                                logic [VAL_W-1:0] v);
        int gap;
        req.valid    <= 1'b1;
        req.action   <= a;
        req.key      <= k;
        req.key_hash <= h;
        req.value    <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_slots(logic [CNT_W-1:0] n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int          r;
        int          i;
        action_t     a;
        logic [KEY_W-1:0]  k;
        logic [HASH_W-1:0] h;
        foreach (pool_keys[j])
        begin
            pool_keys[j]   = $urandom;
            pool_hashes[j] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom;
        end
        repeat (count)
        begin
            if ($urandom_range(0, 29) == 0)
                quiet = ~quiet;
            r = $urandom_range(0, 99);
            a = (r < 40) ? ACT_INSERT : (r < 75) ? ACT_FIND : (r < 95) ? ACT_ERASE : ACT_NONE;
            i = $urandom_range(0, 11);
            k = pool_keys[i];
            h = pool_hashes[i];
            r = $urandom_range(0, 99);
            if (r < 8)
                k = $urandom;
            else if (r < 16)
                h = $urandom;
            send_request(a, k, h, $urandom);
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] slot_plan[10];
        slot_plan = '{16, 5, 2, 1024, 0, 1, 3, 2047, 59, 7};
        quiet     = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        req.valid    = 1'b0;
        req.action   = ACT_INSERT;
        req.key      = '0;
        req.key_hash = '0;
        req.value    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_INSERT, 32'h0, 32'h0, 32'h0);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_FIND, 32'h0, 32'h0, 32'h1234_5678);
        send_request(ACT_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_FIND, 32'h5555_5555, 32'h0, 32'h0);
        send_request(ACT_ERASE, 32'hAAAA_AAAA, 32'h0, 32'h0);
        send_request(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'h11, 32'd5, 32'hA1);
        send_request(ACT_INSERT, 32'h22, 32'd64, 32'hA2);
        send_request(ACT_INSERT, 32'h33, 32'd5, 32'hA3);
        send_request(ACT_ERASE, 32'h11, 32'd5, 32'h0);
        send_request(ACT_FIND, 32'h33, 32'd5, 32'h0);
        send_request(ACT_FIND, 32'h22, 32'd5, 32'h0);
        send_request(ACT_ERASE, 32'h22, 32'd5, 32'h0);
        send_request(ACT_INSERT, 32'h44, 32'd5, 32'hA4);
        send_request(ACT_ERASE, 32'h33, 32'd5, 32'h0);
        send_request(ACT_ERASE, 32'h0, 32'h0, 32'h0);
        set_slots(2);
        send_request(ACT_INSERT, 32'h55, 32'd1, 32'hA5);
        send_request(ACT_INSERT, 32'h66, 32'd1, 32'hA6);
        send_request(ACT_FIND, 32'h55, 32'd1, 32'h0);

        foreach (slot_plan[p])
        begin
            set_slots(slot_plan[p]);
            random_phase(133);
        end

        quiet = 1'b0;
        drain();
        if (fail_count == 0)
            $display("** linear_probe_hash_table: PASSED **");
        else
            $display("** linear_probe_hash_table: FAILED **");
        $finish;
    end

endmodule

// File: linear_probe_hash_table.f
rtl/lpht_pkg.sv
rtl/lpht_if.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
tb/lpht_checker.sv
tb/testbench.sv
